/* rtl/core/slid_pkg.sv */
// ----------------------------------------------------------------------------
// slid_pkg: shared types and constants of the sorted list unit
// Status codes, entry width, default capacity and the operation bundle
// that the top level broadcasts to every cell of the row.
// ----------------------------------------------------------------------------
package slid_pkg;

  localparam int ENTRY_W      = 32;
  localparam int CAPACITY_DEF = 16;
  localparam int REPORT_W     = 5;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } slid_status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } slid_cmd_t;

  // Operation broadcast to every cell in the cycle it is applied
  typedef struct packed {
    logic                       apply;
    logic                       del;
    logic                       full;
    logic                       found;
    logic signed [ENTRY_W-1:0]  value;
  } slid_op_t;

endpackage

/* rtl/core/slid_if.sv */
// ----------------------------------------------------------------------------
// slid_if: channel interfaces of the sorted list unit
// Valid/ready channels for commands in and status results out.
// ----------------------------------------------------------------------------
interface slid_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [slid_pkg::ENTRY_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface slid_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           status;
  logic [slid_pkg::REPORT_W-1:0]        entry_count;
  logic                                 list_empty;

  modport source (output valid, output status, output entry_count, output list_empty,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input list_empty,
                  output ready);
endinterface

/* rtl/core/sorted_list_insert_delete_unit.sv */
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_unit: sorted insertion list on a row of cells
// Keeps up to CAPACITY signed values in ascending order. Each command
// inserts a value in order or deletes the first equal entry, and returns
// a status with the new count.
//
//   channel | dir | handshake    | payload
//   in_ch   | in  | valid/ready  | command, value
//   out_ch  | out | valid/ready  | status, entry_count, list_empty
//
// Each item is first captured into the single command slot; it is then
// applied, and all cells compare against the value and shift in parallel.
// The slot holds one command, so in_ch is not ready again until it is applied.
// Reset (rst_n, synchronous, active low) clears the count and the handshake
// state; entry contents are left as they are.
// A stalled result waits in the output register while the next command is
// captured; that command is applied once the register is free.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_unit #(
  parameter int CAPACITY = slid_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  slid_in_if.sink           in_ch,
  slid_out_if.source        out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Command slot
  logic                                busy_r;
  logic                                busy_nxt;
  logic                                cmd_r;
  logic signed [slid_pkg::ENTRY_W-1:0] value_r;

  // List count
  logic [CNT_W-1:0]                    count_r;
  logic [CNT_W-1:0]                    count_nxt;

  // Output register
  logic                                out_valid_r;
  logic                                out_valid_nxt;
  slid_pkg::slid_status_t              status_r;
  slid_pkg::slid_status_t              status_nxt;
  logic [CNT_W-1:0]                    out_cnt_r;

  // Row signals
  slid_pkg::slid_op_t                  op;
  logic                                apply;
  logic                                full;
  logic                                found;
  logic [CAPACITY-1:0]                 ge_vec;
  logic [CAPACITY-1:0]                 eq_vec;
  logic signed [slid_pkg::ENTRY_W-1:0] entry_vec [CAPACITY];
  logic [CNT_W+slid_pkg::REPORT_W-1:0] cnt_ext;

  // Apply the held command once the output register can take its result
  assign apply = busy_r && (!out_valid_r || out_ch.ready);
  assign full  = (count_r == CNT_W'(CAPACITY));
  assign found = |eq_vec;

  assign op.apply = apply;
  assign op.del   = (cmd_r == slid_pkg::CMD_DELETE);
  assign op.full  = full;
  assign op.found = found;
  assign op.value = value_r;

  // Build the row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                                ge_left;
    logic signed [slid_pkg::ENTRY_W-1:0] entry_left;
    logic signed [slid_pkg::ENTRY_W-1:0] entry_right;

    if (i == 0) begin : g_head
      assign ge_left    = 1'b0;
      assign entry_left = '0;
    end else begin : g_body
      assign ge_left    = ge_vec[i-1];
      assign entry_left = entry_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign entry_right = '0;
    end else begin : g_link
      assign entry_right = entry_vec[i+1];
    end

    slid_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .op          (op),
      .count       (count_r),
      .ge_left     (ge_left),
      .entry_left  (entry_left),
      .entry_right (entry_right),
      .ge_self     (ge_vec[i]),
      .first_eq    (eq_vec[i]),
      .entry       (entry_vec[i])
    );
  end

  // Work out the status and next count of the applied command
  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    if (apply) begin
      if (cmd_r == slid_pkg::CMD_INSERT) begin
        if (full) begin
          status_nxt = slid_pkg::ST_FULL;
        end else begin
          status_nxt = slid_pkg::ST_INSERTED;
          count_nxt  = count_r + CNT_W'(1);
        end
      end else if (found) begin
        status_nxt = slid_pkg::ST_DELETED;
        count_nxt  = count_r - CNT_W'(1);
      end else begin
        status_nxt = slid_pkg::ST_NOT_FOUND;
      end
    end
  end

  // Command slot and output handshake
  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (apply) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end
    if (in_ch.valid && in_ch.ready) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // Capture the command and the result payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r   <= in_ch.command;
      value_r <= in_ch.value;
    end
    if (apply) begin
      status_r  <= status_nxt;
      out_cnt_r <= count_nxt;
    end
  end

  assign in_ch.ready = !busy_r;

  // Report the low bits of the count; the empty flag stays exact
  assign cnt_ext            = (CNT_W + slid_pkg::REPORT_W)'(out_cnt_r);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.entry_count = cnt_ext[slid_pkg::REPORT_W-1:0];
  assign out_ch.list_empty  = (out_cnt_r == '0);

  // Count never goes past the capacity
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list count exceeds capacity");

  // At most one cell claims to be the first equal entry
  a_first_eq_unique : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> $onehot0(eq_vec))
    else $error("more than one first-equal cell");

  // A successful insert grows the list by one
  a_insert_count : assert property (@(posedge clk) disable iff (!rst_n)
    (apply && cmd_r == slid_pkg::CMD_INSERT && !full) |=>
      (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not advance the count");

  // A result is never overwritten while it waits for transfer
  a_result_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(status_r)
      && $stable(out_cnt_r)))
    else $error("pending result changed");

endmodule

/* rtl/core/slid_cell.sv */
// ----------------------------------------------------------------------------
// slid_cell: one slot of the sorted row
// Holds one entry, compares it with the broadcast value and, when an op is
// applied, takes the value or its own, left or right neighbour's entry.
// ----------------------------------------------------------------------------
module slid_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                                clk,
  input  slid_pkg::slid_op_t                  op,
  input  logic [CNT_W-1:0]                    count,
  input  logic                                ge_left,
  input  logic signed [slid_pkg::ENTRY_W-1:0] entry_left,
  input  logic signed [slid_pkg::ENTRY_W-1:0] entry_right,
  output logic                                ge_self,
  output logic                                first_eq,
  output logic signed [slid_pkg::ENTRY_W-1:0] entry
);

  logic                                slot_valid;
  logic signed [slid_pkg::ENTRY_W-1:0] entry_r;
  logic signed [slid_pkg::ENTRY_W-1:0] entry_nxt;

  // Slot is occupied when its index is below the count
  assign slot_valid = (CNT_W'(IDX) < count);

  // At or past the insert point: an entry >= value, or a free slot
  assign ge_self  = !slot_valid || (entry_r >= op.value);

  // First equal entry: equal here and the left neighbour is still below
  assign first_eq = slot_valid && (entry_r == op.value) && !ge_left;

  assign entry = entry_r;

  // Select the next entry: shift right on insert, left on delete
  always_comb begin
    entry_nxt = entry_r;
    if (op.apply) begin
      if (!op.del) begin
        if (!op.full) begin
          if (ge_left) begin
            entry_nxt = entry_left;
          end else if (ge_self) begin
            entry_nxt = op.value;
          end
        end
      end else if (op.found && ge_self) begin
        entry_nxt = entry_right;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* sim/tb_sorted_list_insert_delete_unit.sv */
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_delete_unit: self-checking bench of the sorted list
// Drives insert and delete commands with random gaps, keeps its own sorted
// copy of the store to predict status, count and empty flag, and compares
// every returned result in order. One long output stall fills the block.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_delete_unit;

  localparam int CAP         = slid_pkg::CAPACITY_DEF;
  localparam int RANDOM_OPS  = 1500;
  localparam int PHASE_LEN   = 100;
  localparam int LONG_HOLD   = 120;
  localparam int IDLE_LIMIT  = 1000;
  localparam int DRAIN_WAIT  = 8;
  localparam int MAX_REPORTS = 10;

  localparam logic signed [slid_pkg::ENTRY_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [slid_pkg::ENTRY_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    slid_pkg::slid_status_t          status;
    logic [slid_pkg::REPORT_W-1:0]   entry_count;
    logic                            list_empty;
  } list_result_t;

  // Shadow of the sorted store plus the results still owed by the block
  class sorted_list_scoreboard;
    logic signed [slid_pkg::ENTRY_W-1:0] stored_values [CAP];
    int unsigned                         stored_count;
    list_result_t                        results_due [$];
    int unsigned                         mismatches;
    int unsigned                         checked;
    int unsigned                         n_inserted, n_deleted, n_not_found, n_full;

    function new();
      stored_count = 0;
      mismatches   = 0;
      checked      = 0;
      n_inserted   = 0;
      n_deleted    = 0;
      n_not_found  = 0;
      n_full       = 0;
    endfunction

    // Apply one accepted command to the shadow and queue its result
    function void note_command(slid_pkg::slid_cmd_t cmd,
                               logic signed [slid_pkg::ENTRY_W-1:0] v);
      int unsigned            pos;
      slid_pkg::slid_status_t st;
      list_result_t           res;
      pos = 0;
      if (cmd == slid_pkg::CMD_INSERT) begin
        if (stored_count >= CAP) begin
          st = slid_pkg::ST_FULL;
          n_full++;
        end else begin
          while (pos < stored_count && stored_values[pos] < v) pos++;
          for (int i = stored_count; i > pos; i--) stored_values[i] = stored_values[i-1];
          stored_values[pos] = v;
          stored_count++;
          st = slid_pkg::ST_INSERTED;
          n_inserted++;
        end
      end else begin
        while (pos < stored_count && stored_values[pos] != v) pos++;
        if (pos >= stored_count) begin
          st = slid_pkg::ST_NOT_FOUND;
          n_not_found++;
        end else begin
          for (int i = pos; i + 1 < stored_count; i++) stored_values[i] = stored_values[i+1];
          stored_count--;
          st = slid_pkg::ST_DELETED;
          n_deleted++;
        end
      end
      res.status      = st;
      res.entry_count = stored_count[slid_pkg::REPORT_W-1:0];
      res.list_empty  = (stored_count == 0);
      results_due.push_back(res);
    endfunction

    // Compare one returned result against the oldest owed one
    function void check_result(logic [1:0] st, logic [slid_pkg::REPORT_W-1:0] cnt,
                               logic empty);
      list_result_t want;
      checked++;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result status=%0d count=%0d empty=%0b",
                   st, cnt, empty);
        return;
      end
      want = results_due.pop_front();
      if (st !== want.status || cnt !== want.entry_count || empty !== want.list_empty) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result %0d: status %0d/%0d count %0d/%0d empty %0b/%0b (exp/got)",
                   checked, want.status, st, want.entry_count, cnt, want.list_empty, empty);
      end
    endfunction

    // Value currently held, for deletes that hit
    function logic signed [slid_pkg::ENTRY_W-1:0] pick_stored();
      return stored_values[$urandom_range(0, stored_count - 1)];
    endfunction
  endclass

  logic clk;
  logic rst_n;

  slid_in_if  in_ch ();
  slid_out_if out_ch ();

  sorted_list_insert_delete_unit #(
    .CAPACITY (CAP)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sorted_list_scoreboard sb = new();

  int unsigned send_mode;      // 0 back to back, 1 random gaps, 2 occasional gaps
  bit          hold_request;   // ask the receiver for one long stall
  int unsigned idle_cycles;
  logic signed [slid_pkg::ENTRY_W-1:0] value_pool [8];

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle gap drawn per item according to the mode in force
  function automatic int unsigned draw_gap(int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 14);
      default: return ($urandom_range(0, 99) < 80) ? 0 : $urandom_range(1, 14);
    endcase
  endfunction

  // Offer one command and hold it until the transfer
  task automatic send_command(slid_pkg::slid_cmd_t cmd,
                              logic signed [slid_pkg::ENTRY_W-1:0] v);
    int unsigned gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.value   <= v;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(cmd, v);
  endtask

  // Random value, biased towards the sign extremes now and then
  function automatic logic signed [slid_pkg::ENTRY_W-1:0] random_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return VAL_MIN + $urandom_range(0, 3);
    if (r == 1) return VAL_MAX - $urandom_range(0, 3);
    return $urandom;
  endfunction

  // Result side: draw a stall per item, take the long hold when asked
  initial begin
    int unsigned stall;
    int unsigned recv_mode;
    int unsigned taken;
    out_ch.ready <= 1'b0;
    recv_mode = 1;
    taken     = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 50 == 0) recv_mode = $urandom_range(0, 2);
      stall = draw_gap(recv_mode);
      if (hold_request) begin
        hold_request = 1'b0;
        stall        = LONG_HOLD;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.status, out_ch.entry_count, out_ch.list_empty);
      taken++;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
    $display("sorted_list_insert_delete_unit: mismatch");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned insert_pct;
    int unsigned r;
    slid_pkg::slid_cmd_t cmd;
    logic signed [slid_pkg::ENTRY_W-1:0] v;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= slid_pkg::CMD_INSERT;
    in_ch.value   <= '0;
    hold_request   = 1'b0;
    send_mode      = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty delete, extremes, duplicates, fill, full drop, deletes
    send_command(slid_pkg::CMD_DELETE, 0);
    send_command(slid_pkg::CMD_INSERT, 0);
    send_command(slid_pkg::CMD_INSERT, VAL_MAX);
    send_command(slid_pkg::CMD_INSERT, VAL_MIN);
    send_command(slid_pkg::CMD_INSERT, -1);
    send_command(slid_pkg::CMD_INSERT, 0);
    send_command(slid_pkg::CMD_DELETE, 0);
    send_command(slid_pkg::CMD_INSERT, 1);
    send_command(slid_pkg::CMD_INSERT, 32'sh5555_5555);
    send_command(slid_pkg::CMD_INSERT, 32'shAAAA_AAAA);
    send_command(slid_pkg::CMD_INSERT, VAL_MIN);
    send_command(slid_pkg::CMD_INSERT, VAL_MAX);
    send_command(slid_pkg::CMD_INSERT, -2);
    send_command(slid_pkg::CMD_INSERT, 100);
    send_command(slid_pkg::CMD_INSERT, -100);
    send_command(slid_pkg::CMD_INSERT, 7);
    send_command(slid_pkg::CMD_INSERT, 0);
    send_command(slid_pkg::CMD_INSERT, -1);
    send_command(slid_pkg::CMD_INSERT, 42);
    send_command(slid_pkg::CMD_INSERT, 5);
    send_command(slid_pkg::CMD_DELETE, 12345);
    send_command(slid_pkg::CMD_DELETE, VAL_MIN);
    send_command(slid_pkg::CMD_DELETE, VAL_MAX);
    send_command(slid_pkg::CMD_DELETE, -1);

    // Small pool so that duplicates and hitting deletes are common
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = 0;
    value_pool[3] = -1;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    // Random: phases lean towards filling, draining or churning the store
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ((n / PHASE_LEN) % 3)
          0:       insert_pct = 85;
          1:       insert_pct = 20;
          default: insert_pct = 55;
        endcase
        send_mode = $urandom_range(0, 2);
        // Once: stall the output while inputs keep coming back to back
        if (n == 4 * PHASE_LEN) begin
          send_mode    = 0;
          hold_request = 1'b1;
        end
      end
      r   = $urandom_range(0, 99);
      cmd = ($urandom_range(0, 99) < insert_pct) ? slid_pkg::CMD_INSERT
                                                 : slid_pkg::CMD_DELETE;
      if (cmd == slid_pkg::CMD_DELETE && sb.stored_count > 0 && r < 70)
        v = sb.pick_stored();
      else if (r < 85)
        v = value_pool[$urandom_range(0, 7)];
      else
        v = random_value();
      send_command(cmd, v);
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every owed result before the summary
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d commands: %0d inserted, %0d deleted, %0d missed, %0d dropped full",
             sb.n_inserted + sb.n_deleted + sb.n_not_found + sb.n_full,
             sb.n_inserted, sb.n_deleted, sb.n_not_found, sb.n_full);
    $display("Results checked: %0d, mismatches: %0d", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("sorted_list_insert_delete_unit: match");
    end else begin
      $display("sorted_list_insert_delete_unit: mismatch");
    end
    $finish;
  end

endmodule

/* sorted_list_insert_delete_unit.f */
rtl/core/slid_pkg.sv
rtl/core/slid_if.sv
rtl/core/slid_cell.sv
rtl/core/sorted_list_insert_delete_unit.sv
sim/tb_sorted_list_insert_delete_unit.sv
